// ===== rtl/core/zero_suppress_bunch_builder_assert.svh =====
// Assertion macros shared by the bunch builder RTL.
// Define NO_ASSERTIONS to compile every check away; no other dependencies.
`ifndef ZERO_SUPPRESS_BUNCH_BUILDER_ASSERT_SVH
`define ZERO_SUPPRESS_BUNCH_BUILDER_ASSERT_SVH

`ifndef NO_ASSERTIONS

// Clocked check, disabled while reset is high.
`define ZSBB_ASSERT(LABEL, CLK, RST, PROP, MSG) \
  LABEL: assert property (@(posedge CLK) disable iff (RST) PROP) else $error(MSG);

// Clocked check that also holds during reset.
`define ZSBB_ASSERT_ALWAYS(LABEL, CLK, PROP, MSG) \
  LABEL: assert property (@(posedge CLK) PROP) else $error(MSG);

`else

`define ZSBB_ASSERT(LABEL, CLK, RST, PROP, MSG)
`define ZSBB_ASSERT_ALWAYS(LABEL, CLK, PROP, MSG)

`endif

`endif

// ===== rtl/core/zsbb_pkg.sv =====
// Shared types and constants of the zero-suppression bunch builder.
// Used by the controller, the datapath and the top level; no dependencies.
package zsbb_pkg;

  localparam int unsigned ADC_W        = 16;
  localparam int unsigned WORD_W       = 15;
  localparam int unsigned RATIO_W      = 16;
  localparam int unsigned CFG_IDX_W    = 3;
  localparam int unsigned CFG_DATA_W   = 16;
  localparam int unsigned PROD_W       = 31;
  localparam int unsigned HEADER_WORDS = 2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ZS_THRESHOLD   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_OVERFLOW_LIMIT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LOW_GAIN_MODE  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_RATIO_Q8  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_INV_RATIO_Q16  = 3'd4;

  // Reset values of the configuration registers
  localparam logic [WORD_W-1:0]  RST_OVERFLOW_LIMIT = 15'd1023;
  localparam logic [RATIO_W-1:0] RST_GAIN_RATIO_Q8  = 16'd4096;
  localparam logic [RATIO_W-1:0] RST_INV_RATIO_Q16  = 16'd4096;

  typedef enum logic [1:0] {
    KIND_LEN   = 2'd0,
    KIND_START = 2'd1,
    KIND_ADC   = 2'd2
  } word_kind_t;

  typedef enum logic [4:0] {
    ST_IDLE       = 5'b00001,
    ST_DECIDE     = 5'b00010,
    ST_EMIT_LEN   = 5'b00100,
    ST_EMIT_START = 5'b01000,
    ST_EMIT_DATA  = 5'b10000
  } state_t;

  typedef struct packed {
    logic capture;
    logic decide;
    logic load_len;
    logic load_start;
    logic load_data;
  } zsbb_cmd_t;

  typedef struct packed {
    logic emit;
    logic out_free;
    logic last_data;
  } zsbb_status_t;

endpackage

// ===== rtl/core/zsbb_ctrl.sv =====
// Sequencer of the bunch builder: accept, decide, then emit header and data for a closed bunch.
// Depends on zsbb_pkg and the assertion macro header.
`include "zero_suppress_bunch_builder_assert.svh"

module zsbb_ctrl
  import zsbb_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         in_valid,
  output logic         in_ready,
  input  zsbb_status_t status,
  output zsbb_cmd_t    cmd
);

  state_t state;
  state_t state_next;

  assign in_ready = (state == ST_IDLE);

  always_comb begin
    cmd            = '0;
    cmd.capture    = in_valid && (state == ST_IDLE);
    cmd.decide     = (state == ST_DECIDE);
    cmd.load_len   = (state == ST_EMIT_LEN) && status.out_free;
    cmd.load_start = (state == ST_EMIT_START) && status.out_free;
    cmd.load_data  = (state == ST_EMIT_DATA) && status.out_free;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) state_next = ST_DECIDE;
      end
      ST_DECIDE: begin
        state_next = status.emit ? ST_EMIT_LEN : ST_IDLE;
      end
      ST_EMIT_LEN: begin
        if (status.out_free) state_next = ST_EMIT_START;
      end
      ST_EMIT_START: begin
        if (status.out_free) state_next = ST_EMIT_DATA;
      end
      ST_EMIT_DATA: begin
        if (status.out_free && status.last_data) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  `ZSBB_ASSERT(a_capture_then_decide, clk, rst, cmd.capture |=> (state == ST_DECIDE), "capture not followed by decide")
  `ZSBB_ASSERT(a_last_word_frees_input, clk, rst, (cmd.load_data && status.last_data) |=> in_ready, "input not released after last data word")

endmodule

// ===== rtl/core/zsbb_datapath.sv =====
// Datapath of the bunch builder: config registers, scaling, bunch store, output register.
// Depends on zsbb_pkg and the assertion macro header.
`include "zero_suppress_bunch_builder_assert.svh"

module zsbb_datapath
  import zsbb_pkg::*;
#(
  parameter int unsigned SAMPLES = 62
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_valid,
  input  logic [CFG_IDX_W-1:0]    cfg_index,
  input  logic [CFG_DATA_W-1:0]   cfg_data,
  input  logic signed [ADC_W-1:0] sample,
  input  logic                    final_sample,
  input  logic                    out_ready,
  output logic                    out_valid,
  output logic [WORD_W-1:0]       word,
  output logic [1:0]              word_kind,
  output logic                    bunch_end,
  input  zsbb_cmd_t               cmd,
  output zsbb_status_t            status
);

  localparam int unsigned AW = $clog2(SAMPLES);
  localparam int unsigned LW = $clog2(SAMPLES + 1);
  localparam int unsigned TW = $clog2(SAMPLES);

  // Configuration
  logic [WORD_W-1:0]  zs_threshold;
  logic [WORD_W-1:0]  overflow_limit;
  logic               low_gain_mode;
  logic [RATIO_W-1:0] gain_ratio_q8;
  logic [RATIO_W-1:0] inv_ratio_q16;

  // Captured item and products
  logic signed [ADC_W-1:0] samp;
  logic                    fin;
  logic [PROD_W-1:0]       prod_thr;
  logic [PROD_W-1:0]       prod_val;

  // Bunch state
  logic [TW-1:0]     time_index;
  logic [LW-1:0]     len;
  logic [LW-1:0]     start_time;
  logic [WORD_W-1:0] mem [SAMPLES];
  logic [WORD_W-1:0] rd_data;
  logic [AW-1:0]     idx;
  logic [AW-1:0]     idx_next;

  // Decide stage
  logic              keep_hi;
  logic              keep_lo;
  logic              keep;
  logic [WORD_W-1:0] raw_val;
  logic [WORD_W-1:0] value;
  logic              ending;
  logic [LW-1:0]     t_plus;
  logic [LW-1:0]     start_val;
  logic              mem_we;
  logic              last_data;
  logic              out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      zs_threshold   <= '0;
      overflow_limit <= RST_OVERFLOW_LIMIT;
      low_gain_mode  <= 1'b0;
      gain_ratio_q8  <= RST_GAIN_RATIO_Q8;
      inv_ratio_q16  <= RST_INV_RATIO_Q16;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_ZS_THRESHOLD:   zs_threshold   <= cfg_data[WORD_W-1:0];
        REG_OVERFLOW_LIMIT: overflow_limit <= cfg_data[WORD_W-1:0];
        REG_LOW_GAIN_MODE:  low_gain_mode  <= cfg_data[0];
        REG_GAIN_RATIO_Q8:  gain_ratio_q8  <= cfg_data;
        REG_INV_RATIO_Q16:  inv_ratio_q16  <= cfg_data;
        default: ;
      endcase
    end
  end

  // Register the sample together with both products
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      samp     <= sample;
      fin      <= final_sample;
      prod_thr <= PROD_W'(zs_threshold) * PROD_W'(gain_ratio_q8);
      prod_val <= PROD_W'(sample[WORD_W-1:0]) * PROD_W'(inv_ratio_q16);
    end
  end

  always_comb begin
    keep_hi   = !samp[ADC_W-1] && (samp[WORD_W-1:0] > zs_threshold);
    keep_lo   = !samp[ADC_W-1] && (samp[WORD_W-1:0] != '0)
                && ({8'b0, samp[WORD_W-1:0], 8'b0} > prod_thr);
    keep      = low_gain_mode ? keep_lo : keep_hi;
    raw_val   = low_gain_mode ? prod_val[PROD_W-1:RATIO_W] : samp[WORD_W-1:0];
    value     = (raw_val > overflow_limit) ? overflow_limit : raw_val;
    ending    = fin || (time_index == '0);
    t_plus    = LW'(time_index) + LW'(1);
    start_val = keep ? '0 : (ending ? LW'(1) : t_plus);
    mem_we    = cmd.decide && keep && (len < LW'(SAMPLES));
    last_data = ((LW'(idx) + LW'(1)) == len);
    out_free  = !out_valid || out_ready;
  end

  always_comb begin
    status           = '0;
    status.emit      = keep ? ending : (len != '0);
    status.out_free  = out_free;
    status.last_data = last_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      time_index <= TW'(SAMPLES - 1);
      len        <= '0;
    end else if (cmd.decide) begin
      time_index <= ending ? TW'(SAMPLES - 1) : time_index - TW'(1);
      if (mem_we) len <= len + LW'(1);
    end else if (cmd.load_data && last_data) begin
      len <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.decide) start_time <= start_val;
  end

  // Read address runs one step ahead so rd_data always matches idx
  always_comb begin
    idx_next = idx;
    if (cmd.decide) begin
      idx_next = '0;
    end else if (cmd.load_data && !last_data) begin
      idx_next = idx + AW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= '0;
    end else begin
      idx <= idx_next;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[len[AW-1:0]] <= value;
    rd_data <= mem[idx_next];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_len || cmd.load_start || cmd.load_data) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_len) begin
      word      <= WORD_W'(len) + WORD_W'(HEADER_WORDS);
      word_kind <= KIND_LEN;
      bunch_end <= 1'b0;
    end else if (cmd.load_start) begin
      word      <= WORD_W'(start_time);
      word_kind <= KIND_START;
      bunch_end <= 1'b0;
    end else if (cmd.load_data) begin
      word      <= rd_data;
      word_kind <= KIND_ADC;
      bunch_end <= last_data;
    end
  end

  `ZSBB_ASSERT(a_len_bound, clk, rst, len <= LW'(SAMPLES), "bunch length beyond store depth")
  `ZSBB_ASSERT(a_len_word_min, clk, rst, (out_valid && (word_kind == KIND_LEN)) |-> (word > WORD_W'(HEADER_WORDS)), "length word for an empty bunch")
  `ZSBB_ASSERT(a_end_on_adc, clk, rst, (out_valid && bunch_end) |-> (word_kind == KIND_ADC), "bunch end flag on a header word")

endmodule

// ===== rtl/core/zero_suppress_bunch_builder.sv =====
// Zero-suppression bunch builder: top level joining controller and datapath.
// Timing: an item is decided in the cycle after acceptance; the first word of a bunch
//   loads the output register from the emit-length state, once that register is free.
// Flow: one item at a time through the capture/decide sequence; an item that closes
//   a bunch of n samples emits n + 2 words through the output register before the next.
// Reset (rst, synchronous, active high): idle, registers at defaults, empty bunch.
module zero_suppress_bunch_builder
  import zsbb_pkg::*;
#(
  parameter int unsigned SAMPLES = 62
) (
  input  logic                    clk,
  input  logic                    rst,

  // Configuration write channel
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [CFG_IDX_W-1:0]    cfg_index,
  input  logic [CFG_DATA_W-1:0]   cfg_data,

  // Sample channel, latest time first
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic signed [ADC_W-1:0] sample,
  input  logic                    final_sample,

  // Result word channel
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [WORD_W-1:0]       word,
  output logic [1:0]              word_kind,
  output logic                    bunch_end
);

  zsbb_cmd_t    cmd;
  zsbb_status_t status;

  // Configuration must only be written while idle (the block does not enforce this), so take every transaction at once.
  assign cfg_ready = 1'b1;

  // Controller: one-hot sequencer. Accept a sample in idle, decide keep/close in the
  // next cycle, then, if a bunch closes, walk its length word, start time and stored values.
  // It holds input ready low until the last word of a bunch sits in the output register.
  zsbb_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  // Datapath: the threshold and scaling products are registered at acceptance; the
  // decide cycle compares, clamps and appends to the bunch store (one write port, one
  // registered read port). The output register parts the result channel from the
  // sequencer, so a waiting word never blocks the next sample once the bunch is out.
  zsbb_datapath #(
    .SAMPLES (SAMPLES)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .sample       (sample),
    .final_sample (final_sample),
    .out_ready    (out_ready),
    .out_valid    (out_valid),
    .word         (word),
    .word_kind    (word_kind),
    .bunch_end    (bunch_end),
    .cmd          (cmd),
    .status       (status)
  );

endmodule
